### design/itoa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, codes and character constants of the integer to ascii
// radix formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    // radix codes of the input item; code 3 is treated as hexadecimal
    localparam logic [1:0] RADIX_HEX = 2'd0;
    localparam logic [1:0] RADIX_DEC = 2'd1;
    localparam logic [1:0] RADIX_BIN = 2'd2;

    // ascii characters used by the formatter
    localparam logic [6:0] CHAR_ZERO   = 7'h30;
    localparam logic [6:0] CHAR_NINE   = 7'h39;
    localparam logic [6:0] CHAR_LOWER_A = 7'h61;
    localparam logic [6:0] CHAR_LOWER_F = 7'h66;
    localparam logic [6:0] CHAR_SPACE  = 7'h20;
    localparam logic [6:0] CHAR_MINUS  = 7'h2d;
    localparam logic [6:0] CHAR_PLUS   = 7'h2b;

    // first digit value that prints as a letter
    localparam logic [3:0] HEX_LETTER_BASE = 4'hA;

    // input item
    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  radix_select;
        logic [5:0]  field_width;
        logic        zero_fill;
        logic        show_plus;
        logic        show_minus;
    } s_item_t;

    // result item
    typedef struct packed {
        logic [6:0] character;
        logic       last_char;
    } m_item_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_EXTRACT,
        ST_FILL,
        ST_SIGN,
        ST_DIGIT
    } itoa_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic extract;
        logic emit_fill;
        logic emit_sign;
        logic emit_digit;
    } itoa_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic dec_mode;
        logic last_step;
        logic fill_more;
        logic has_sign;
        logic last_digit;
    } itoa_stat_t;

endpackage
`default_nettype wire

### design/integer_to_ascii_radix_formatter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_formatter_top
// Converts a 32-bit magnitude to ascii: fill, optional sign, then digits.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one number item (value, radix, width, fill and sign
//   flags); m_ channel returns the ascii characters one per m_ item, last_char set
//   on the final digit of the number.
//   Digit extraction: hex and binary pass ST_MUL once as setup, then take
//   a digit in each ST_EXTRACT step; decimal alternates ST_MUL (reciprocal
//   multiply) and ST_EXTRACT (remainder) for each digit with no separate
//   setup. Emission: one character per cycle into the output register while
//   the receiver does not stall; leaving the fill phase and passing an
//   absent sign emit no character.
//   One number is worked on at a time; s_ready is high again once the last
//   digit sits in the output register, while that character still waits.
//   Reset (aresetn low, synchronous) returns to idle and empties the output.
//   When the receiver stalls, the output register holds its character and
//   the sequencer waits before its next emission.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_formatter_top #(
    parameter int MAX_DIGITS = 32,
    parameter int MAX_WIDTH  = 63
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire itoa_pkg::s_item_t s_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output itoa_pkg::m_item_t      m_item
);

    itoa_pkg::itoa_cmd_t  cmd;
    itoa_pkg::itoa_stat_t stat;

    itoa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    itoa_dpath #(
        .MAX_DIGITS (MAX_DIGITS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule
`default_nettype wire

### design/itoa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencer of the formatter: digit extraction loop, then fill, sign and
// digit emission phases, one character per cycle into the free output register.
// ----------------------------------------------------------------------------
module itoa_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire itoa_pkg::itoa_stat_t stat,
    output itoa_pkg::itoa_cmd_t     cmd
);

    itoa_pkg::itoa_state_t state_reg;
    itoa_pkg::itoa_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= itoa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            itoa_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = itoa_pkg::ST_MUL;
                end
            end
            itoa_pkg::ST_MUL: begin
                // quotient by ten for decimal, harmless otherwise
                cmd.mul    = 1'b1;
                state_next = itoa_pkg::ST_EXTRACT;
            end
            itoa_pkg::ST_EXTRACT: begin
                cmd.extract = 1'b1;
                if (stat.last_step) begin
                    state_next = itoa_pkg::ST_FILL;
                end else if (stat.dec_mode) begin
                    state_next = itoa_pkg::ST_MUL;
                end
            end
            itoa_pkg::ST_FILL: begin
                if (!stat.fill_more) begin
                    state_next = itoa_pkg::ST_SIGN;
                end else if (stat.out_free) begin
                    cmd.emit_fill = 1'b1;
                end
            end
            itoa_pkg::ST_SIGN: begin
                if (!stat.has_sign) begin
                    state_next = itoa_pkg::ST_DIGIT;
                end else if (stat.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = itoa_pkg::ST_DIGIT;
                end
            end
            itoa_pkg::ST_DIGIT: begin
                if (stat.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (stat.last_digit) begin
                        state_next = itoa_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = itoa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### design/itoa_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_dpath
// Datapath of the formatter: value register, divide-by-ten reciprocal
// multiplier, digit stack, fill counter and output register.
// ----------------------------------------------------------------------------
module itoa_dpath #(
    parameter int MAX_DIGITS = 32,
    parameter int MAX_WIDTH  = 63
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire itoa_pkg::s_item_t    s_item,
    input  wire itoa_pkg::itoa_cmd_t  cmd,
    output itoa_pkg::itoa_stat_t      stat,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output itoa_pkg::m_item_t         m_item
);

    // a 32-bit value never has more than 32 digits
    localparam int DIG_DEPTH = (MAX_DIGITS < 32) ? MAX_DIGITS : 32;
    localparam int CNT_W     = $clog2(DIG_DEPTH + 1);
    localparam int IDX_W     = $clog2(DIG_DEPTH);
    localparam int CMP_W     = 7;
    localparam logic [5:0]  WIDTH_MAX = 6'(MAX_WIDTH);
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

    itoa_pkg::s_item_t item_reg;
    logic [31:0]       val_reg;
    logic [31:0]       val_next;
    logic [28:0]       quot_reg;
    logic [63:0]       product;
    logic [31:0]       quot_ten;
    logic [31:0]       dec_diff;
    logic [3:0]        digit_new;
    logic [CNT_W-1:0]  ndig_reg;
    logic [CNT_W-1:0]  rd_cnt;
    logic [CNT_W-1:0]  rd_addr;
    logic [3:0]        dig_mem [DIG_DEPTH];
    logic [3:0]        digit_rd_reg;
    logic [5:0]        fill_reg;
    logic [5:0]        width_clamped;
    logic              m_valid_reg;
    itoa_pkg::m_item_t m_item_reg;
    itoa_pkg::m_item_t m_item_next;

    // width clamp at load
    assign width_clamped = (s_item.field_width > WIDTH_MAX) ? WIDTH_MAX
                                                            : s_item.field_width;

    // reciprocal multiply, quotient by ten is exact for all 32-bit values
    assign product = 64'(val_reg) * 64'(RECIP_TEN);

    // remainder from the registered quotient
    assign quot_ten = {quot_reg[28:0], 3'b000} + {2'b00, quot_reg[28:0], 1'b0};
    assign dec_diff = val_reg - quot_ten;

    // next digit and shrunk value
    always_comb begin
        unique case (item_reg.radix_select)
            itoa_pkg::RADIX_DEC: begin
                digit_new = dec_diff[3:0];
                val_next  = {3'b000, quot_reg};
            end
            itoa_pkg::RADIX_BIN: begin
                digit_new = {3'b000, val_reg[0]};
                val_next  = {1'b0, val_reg[31:1]};
            end
            default: begin
                digit_new = val_reg[3:0];
                val_next  = {4'h0, val_reg[31:4]};
            end
        endcase
    end

    // conversion registers and digit stack
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_item;
            val_reg  <= s_item.value;
            fill_reg <= width_clamped;
            ndig_reg <= '0;
        end else begin
            if (cmd.mul) begin
                quot_reg <= product[63:35];
            end
            if (cmd.extract) begin
                dig_mem[ndig_reg[IDX_W-1:0]] <= digit_new;
                val_reg  <= val_next;
                ndig_reg <= ndig_reg + CNT_W'(1);
            end
            if (cmd.emit_fill) begin
                fill_reg <= fill_reg - 6'd1;
            end
            if (cmd.emit_digit) begin
                ndig_reg <= rd_cnt;
            end
        end
    end

    // digit stack read, most significant first; the address follows the
    // count after this edge so the next digit is registered before its turn
    assign rd_cnt  = ndig_reg - CNT_W'(1);
    assign rd_addr = cmd.emit_digit ? (rd_cnt - CNT_W'(1)) : rd_cnt;

    always_ff @(posedge aclk) begin
        digit_rd_reg <= dig_mem[rd_addr[IDX_W-1:0]];
    end

    // status toward the controller
    assign stat.out_free   = !m_valid_reg || m_ready;
    assign stat.dec_mode   = (item_reg.radix_select == itoa_pkg::RADIX_DEC);
    assign stat.last_step  = (val_next == 32'd0) || (ndig_reg == CNT_W'(DIG_DEPTH - 1));
    assign stat.fill_more  = {1'b0, fill_reg} > CMP_W'(ndig_reg);
    assign stat.has_sign   = item_reg.show_minus || item_reg.show_plus;
    assign stat.last_digit = (ndig_reg == CNT_W'(1));

    // character selection
    always_comb begin
        m_item_next = '0;
        priority if (cmd.emit_fill) begin
            m_item_next.character = item_reg.zero_fill ? itoa_pkg::CHAR_ZERO
                                                       : itoa_pkg::CHAR_SPACE;
        end else if (cmd.emit_sign) begin
            m_item_next.character = item_reg.show_minus ? itoa_pkg::CHAR_MINUS
                                                        : itoa_pkg::CHAR_PLUS;
        end else begin
            if (digit_rd_reg < itoa_pkg::HEX_LETTER_BASE) begin
                m_item_next.character = itoa_pkg::CHAR_ZERO + 7'(digit_rd_reg);
            end else begin
                m_item_next.character = itoa_pkg::CHAR_LOWER_A
                    + 7'(digit_rd_reg - itoa_pkg::HEX_LETTER_BASE);
            end
            m_item_next.last_char = (ndig_reg == CNT_W'(1));
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_fill || cmd.emit_sign || cmd.emit_digit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_fill || cmd.emit_sign || cmd.emit_digit) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
`default_nettype wire

### design/itoa_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_chk
// Port-level checks of the formatter, bound to the top level.
// ----------------------------------------------------------------------------
module itoa_chk (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire itoa_pkg::m_item_t m_item
);

    // stalled output item holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("output item changed while stalled");

    // one number at a time: no acceptance right after an acceptance
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a number is in progress");

    // only fill, sign, decimal digits and lower-case hex letters appear
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.character == itoa_pkg::CHAR_SPACE)
                 || (m_item.character == itoa_pkg::CHAR_PLUS)
                 || (m_item.character == itoa_pkg::CHAR_MINUS)
                 || ((m_item.character >= itoa_pkg::CHAR_ZERO)
                     && (m_item.character <= itoa_pkg::CHAR_NINE))
                 || ((m_item.character >= itoa_pkg::CHAR_LOWER_A)
                     && (m_item.character <= itoa_pkg::CHAR_LOWER_F)))
        else $error("unexpected output character");

    // a number always ends on a digit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.last_char |->
            ((m_item.character >= itoa_pkg::CHAR_ZERO)
             && (m_item.character <= itoa_pkg::CHAR_NINE))
            || ((m_item.character >= itoa_pkg::CHAR_LOWER_A)
             && (m_item.character <= itoa_pkg::CHAR_LOWER_F)))
        else $error("last character is not a digit");

endmodule

bind integer_to_ascii_radix_formatter_top itoa_chk u_itoa_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
`default_nettype wire
